FILE: rtl/assert_macros.svh
// Assertion macros used by the block bitmap allocator RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked only while reset is released.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/bba_pkg.sv
// Package for the block bitmap allocator: map geometry, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int MAP_WORDS = 1024;
    localparam int WORD_BITS = 32;
    localparam int BIT_AW    = 5;
    localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [32:0]       MAP_BLOCKS = 33'(MAP_WORDS * WORD_BITS);
    localparam logic [MAP_AW-1:0] LAST_WORD  = MAP_AW'(MAP_WORDS - 1);
    localparam logic [31:0]       FULL_WORD  = 32'hffff_ffff;

    localparam int CFG_AW = 3;
    localparam logic REG_BASE_BLOCK = 1'b0;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_USED  = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [MAP_AW-1:0] addr;
        logic [31:0]       wdata;
    } t_mem_req;

endpackage

FILE: rtl/bba_map_ram.sv
// Usage bitmap storage: single-port synchronous RAM with registered read data.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_map_ram
    import bba_pkg::*;
(
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [31:0] o_rdata
);

    logic [31:0] r_mem [MAP_WORDS];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.en && i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en && !i_req.we) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bba_cfg.sv
// APB-style register port holding the base block address.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_cfg
    import bba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready,
    output logic [31:0]       o_base_block
);

    logic [31:0] r_base_block;
    logic        wr_base;

    assign wr_base = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_BASE_BLOCK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_block <= '0;
        end else if (wr_base) begin
            r_base_block <= i_pwdata;
        end
    end

    assign o_prdata     = (i_paddr[2] == REG_BASE_BLOCK) ? r_base_block : 32'd0;
    assign o_pready     = 1'b1;
    assign o_base_block = r_base_block;

endmodule

FILE: rtl/bba_ctrl.sv
// Command sequencer: clear pass, first-fit word scan and read-modify-write marks.
// Depends on bba_pkg and assert_macros.svh; drives bba_map_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bba_ctrl
    import bba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_block_addr,
    input  logic [31:0] i_base_block,
    input  logic [31:0] i_rdata,
    output t_mem_req    o_req,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_result_block,
    output logic [1:0]  o_status
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;

    function automatic logic [BIT_AW-1:0] f_enc(input logic [31:0] onehot);
        logic [BIT_AW-1:0] idx;
        idx = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (onehot[j]) begin
                idx = idx | BIT_AW'(j);
            end
        end
        return idx;
    endfunction

    logic [2:0]        r_state, n_state;
    logic [MAP_AW-1:0] r_word, n_word;
    logic [1:0]        r_cmd, n_cmd;
    logic [31:0]       r_addr, n_addr;
    logic [BIT_AW-1:0] r_bit, n_bit;
    logic              r_done, n_done;
    logic [31:0]       r_result, n_result;
    logic [1:0]        r_status, n_status;

    logic              accept;
    logic [31:0]       offset;
    logic              in_range;
    logic [31:0]       set_word;
    logic [BIT_AW-1:0] free_bit;
    logic [31:0]       bit_mask;
    t_mem_req          req;

    assign accept   = i_start && (r_state == S_IDLE);
    assign offset   = i_block_addr - i_base_block;
    assign in_range = {1'b0, offset} < MAP_BLOCKS;
    // w | (w + 1) sets the lowest clear bit; the xor leaves just that bit
    assign set_word = i_rdata | (i_rdata + 32'd1);
    assign free_bit = f_enc(set_word ^ i_rdata);
    assign bit_mask = 32'd1 << r_bit;

    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_cmd    = r_cmd;
        n_addr   = r_addr;
        n_bit    = r_bit;
        n_done   = 1'b0;
        n_result = r_result;
        n_status = r_status;
        req      = '{en: 1'b0, we: 1'b0, addr: r_word, wdata: 32'd0};

        case (r_state)
            S_CLEAR: begin
                req = '{en: 1'b1, we: 1'b1, addr: r_word, wdata: 32'd0};
                n_word = r_word + MAP_AW'(1);
                if (r_word == LAST_WORD) begin
                    n_word  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd  = i_command;
                    n_addr = i_block_addr;
                    case (i_command)
                        CMD_ALLOC: begin
                            // fetch word zero, check it next cycle
                            req     = '{en: 1'b1, we: 1'b0, addr: '0, wdata: 32'd0};
                            n_word  = '0;
                            n_state = S_SCAN;
                        end
                        CMD_USED, CMD_FREE: begin
                            if (in_range) begin
                                n_word  = offset[MAP_AW+BIT_AW-1:BIT_AW];
                                n_bit   = offset[BIT_AW-1:0];
                                req     = '{en: 1'b1, we: 1'b0,
                                            addr: offset[MAP_AW+BIT_AW-1:BIT_AW],
                                            wdata: 32'd0};
                                n_state = S_MARK;
                            end else begin
                                n_done   = 1'b1;
                                n_result = i_block_addr;
                                n_status = ST_RANGE;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = i_block_addr;
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_MARK: begin
                req = '{en: 1'b1, we: 1'b1, addr: r_word,
                        wdata: (r_cmd == CMD_USED) ? (i_rdata | bit_mask)
                                                   : (i_rdata & ~bit_mask)};
                n_done   = 1'b1;
                n_result = r_addr;
                n_status = ST_OK;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                if (i_rdata != FULL_WORD) begin
                    req = '{en: 1'b1, we: 1'b1, addr: r_word, wdata: set_word};
                    n_done   = 1'b1;
                    n_result = i_base_block + 32'({r_word, free_bit});
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else if (r_word == LAST_WORD) begin
                    n_done   = 1'b1;
                    n_result = 32'd0;
                    n_status = ST_FULL;
                    n_state  = S_IDLE;
                end else begin
                    // advance to the next word
                    req    = '{en: 1'b1, we: 1'b0, addr: r_word + MAP_AW'(1), wdata: 32'd0};
                    n_word = r_word + MAP_AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_word  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_addr   <= n_addr;
        r_bit    <= n_bit;
        r_result <= n_result;
        r_status <= n_status;
    end

    assign o_req          = req;
    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_result_block = r_result;
    assign o_status       = r_status;

    `ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> r_state == S_CLEAR, "reset must start the clear pass")
    `ASSERT_PROP(a_no_done_clear, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !r_done, "result during clear pass")
    `ASSERT_PROP(a_no_wr_idle, i_clk, i_rst_n, (req.en && req.we) |-> (r_state != S_IDLE), "map write while idle")
    `ASSERT_PROP(a_full_zero, i_clk, i_rst_n, (r_done && r_status == ST_FULL) |-> (r_result == 32'd0), "full status with nonzero block")
    `ASSERT_PROP(a_alloc_scan, i_clk, i_rst_n, (accept && i_command == CMD_ALLOC) |=> (r_state == S_SCAN), "allocate did not enter scan")

endmodule

FILE: rtl/block_bitmap_allocator.sv
// Top level of the block bitmap allocator: register port, sequencer and map RAM.
// Depends on bba_pkg, bba_cfg, bba_ctrl and bba_map_ram.
//
//   channel   handshake                    payload
//   command   start / busy                 i_command, i_block_addr
//   result    o_done (one-cycle strobe)    o_result_block, o_status
//   config    psel/penable/pwrite/pready   paddr, pwdata, prdata (base_block at 0x0)
//
// After reset a clearing pass writes all MAP_WORDS map words with busy high.
// Allocate scans the map word by word: the single RAM port reads one word per cycle.
// Mark used/free read the word, then write it back; out-of-range and unused commands do not touch the map.
// The result strobe follows the last cycle of the command; it cannot be stalled.
`timescale 1ns / 1ps

module block_bitmap_allocator
    import bba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [31:0]       i_block_addr,
    output logic              o_done,
    output logic [31:0]       o_result_block,
    output logic [1:0]        o_status,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0] base_block;
    logic [31:0] rdata;
    t_mem_req    mem_req;

    bba_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_prdata     (prdata),
        .o_pready     (pready),
        .o_base_block (base_block)
    );

    bba_map_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    bba_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_command      (i_command),
        .i_block_addr   (i_block_addr),
        .i_base_block   (base_block),
        .i_rdata        (rdata),
        .o_req          (mem_req),
        .o_busy         (busy),
        .o_done         (o_done),
        .o_result_block (o_result_block),
        .o_status       (o_status)
    );

endmodule

FILE: tb/block_bitmap_allocator_test.sv
// Self-checking testbench for block_bitmap_allocator: directed table, wrapped window
// and random commands over several base_block settings, each result checked against a known answer or a bitmap model.
// Depends on bba_pkg and the block_bitmap_allocator RTL.
`timescale 1ns / 1ps

module block_bitmap_allocator_test;
    import bba_pkg::*;

    localparam logic [1:0]        CMD_UNUSED   = 2'd3;
    localparam logic [CFG_AW-1:0] ADDR_BASE    = CFG_AW'(4 * int'(REG_BASE_BLOCK));
    localparam int                QUIET_LIMIT  = 4 * (MAP_WORDS + 64);
    localparam int                N_DIRECTED   = 20;
    localparam int                N_RANDOM     = 94;

    typedef struct packed {
        logic [31:0] blk;
        logic [1:0]  status;
    } t_result;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] addr;
        logic        known;
        logic [31:0] known_blk;
        logic [1:0]  known_status;
    } t_op_row;

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic              busy;
    logic [1:0]        i_command    = CMD_UNUSED;
    logic [31:0]       i_block_addr = '0;
    logic              o_done;
    logic [31:0]       o_result_block;
    logic [1:0]        o_status;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [CFG_AW-1:0] paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;

    block_bitmap_allocator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_block_addr   (i_block_addr),
        .o_done         (o_done),
        .o_result_block (o_result_block),
        .o_status       (o_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Model of the map and the window register
    logic [31:0] usage_shadow [MAP_WORDS];
    logic [31:0] base_shadow;

    t_result     awaited_words [$];
    t_op_row     directed_ops [N_DIRECTED];
    bit          idle_enable;
    int          mismatches;
    int          words_sent;
    int          words_checked;
    int          base_writes;
    int          quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_result bitmap_apply(input logic [1:0] cmd, input logic [31:0] addr);
        t_result     r;
        logic [31:0] offset;
        bit          found;
        r.blk    = addr;
        r.status = ST_OK;
        found    = 1'b0;
        case (cmd)
            CMD_ALLOC: begin
                r.blk    = '0;
                r.status = ST_FULL;
                for (int w = 0; w < MAP_WORDS && !found; w++) begin
                    if (usage_shadow[w] != FULL_WORD) begin
                        for (int b = 0; b < WORD_BITS && !found; b++) begin
                            if (!usage_shadow[w][b]) begin
                                found              = 1'b1;
                                usage_shadow[w][b] = 1'b1;
                                r.blk              = base_shadow + 32'(w * WORD_BITS + b);
                                r.status           = ST_OK;
                            end
                        end
                    end
                end
            end
            CMD_USED, CMD_FREE: begin
                offset = addr - base_shadow;
                if ({1'b0, offset} >= MAP_BLOCKS) begin
                    r.status = ST_RANGE;
                end else begin
                    usage_shadow[offset / WORD_BITS][offset % WORD_BITS] = (cmd == CMD_USED);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_op_row plain_op(input logic [1:0] cmd, input logic [31:0] addr);
        return '{cmd, addr, 1'b0, 32'h0, ST_OK};
    endfunction

    // Called right after a rising edge; returns at the edge that accepts the word.
    task automatic issue(input t_op_row row);
        t_result predicted;
        if (idle_enable && $urandom_range(0, 99) < 29) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= row.cmd;
        i_block_addr <= row.addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = bitmap_apply(row.cmd, row.addr);
        if (row.known) begin
            predicted.blk    = row.known_blk;
            predicted.status = row.known_status;
        end
        awaited_words.push_back(predicted);
        words_sent++;
    endtask

    // Drop start and hold until every result is back.
    task automatic settle();
        start <= 1'b0;
        while (awaited_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BASE;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        base_shadow = value;
        base_writes++;
    endtask

    task automatic run_random(input int count);
        logic [1:0]  cmd;
        logic [31:0] addr;
        int          pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            cmd  = (pick < 35) ? CMD_ALLOC : (pick < 65) ? CMD_USED :
                   (pick < 95) ? CMD_FREE : CMD_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                addr = base_shadow + $urandom_range(0, MAP_WORDS * WORD_BITS - 1);
            else if (pick < 75)
                addr = base_shadow + $urandom_range(0, 63);
            else if (pick < 85)
                addr = base_shadow + 32'(MAP_WORDS * WORD_BITS) - $urandom_range(0, 2);
            else
                addr = $urandom;
            issue(plain_op(cmd, addr));
        end
    endtask

    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (awaited_words.size() == 0) begin
                $display("%0t: result with none awaited: expected none, actual block %h status %0d",
                         $time, o_result_block, o_status);
                mismatches++;
            end else begin
                want = awaited_words.pop_front();
                words_checked++;
                if (o_result_block !== want.blk) begin
                    $display("%0t: result_block expected %h actual %h",
                             $time, want.blk, o_result_block);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1 || (psel && penable && pwrite))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog, nothing moved for %0d cycles", $time, QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        for (int w = 0; w < MAP_WORDS; w++) usage_shadow[w] = '0;
        base_shadow   = '0;
        idle_enable   = 1'b1;
        mismatches    = 0;
        words_sent    = 0;
        words_checked = 0;
        base_writes   = 0;

        // Fresh map, base 0: known answers first, then rows left to the model
        directed_ops = '{
            '{CMD_ALLOC,  32'hDEAD_BEEF, 1'b1, 32'h0000_0000, ST_OK},
            '{CMD_ALLOC,  32'h0000_0000, 1'b1, 32'h0000_0001, ST_OK},
            '{CMD_USED,   32'h0000_7FFF, 1'b1, 32'h0000_7FFF, ST_OK},
            '{CMD_USED,   32'h0000_8000, 1'b1, 32'h0000_8000, ST_RANGE},
            '{CMD_FREE,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_RANGE},
            '{CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_OK},
            '{CMD_UNUSED, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
            '{CMD_FREE,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
            '{CMD_ALLOC,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
            '{CMD_FREE,   32'h0000_0005, 1'b1, 32'h0000_0005, ST_OK},
            '{CMD_USED,   32'h0000_0001, 1'b1, 32'h0000_0001, ST_OK},
            '{CMD_USED,   32'h8000_0000, 1'b1, 32'h8000_0000, ST_RANGE},
            '{CMD_USED,   32'h0000_0002, 1'b0, 32'h0,         ST_OK},
            '{CMD_USED,   32'h0000_001F, 1'b0, 32'h0,         ST_OK},
            '{CMD_ALLOC,  32'h5555_AAAA, 1'b0, 32'h0,         ST_OK},
            '{CMD_USED,   32'h0000_0020, 1'b0, 32'h0,         ST_OK},
            '{CMD_ALLOC,  32'h0000_0000, 1'b0, 32'h0,         ST_OK},
            '{CMD_FREE,   32'h0000_7FFF, 1'b0, 32'h0,         ST_OK},
            '{CMD_FREE,   32'h0000_7FFF, 1'b0, 32'h0,         ST_OK},
            '{CMD_USED,   32'h0000_7FE0, 1'b0, 32'h0,         ST_OK}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) issue(directed_ops[k]);

        // Window straddling the top of the address space: wrapped allocations and marks
        write_base(32'hFFFF_FFF0);
        issue(plain_op(CMD_ALLOC, 32'h0));
        issue(plain_op(CMD_USED, 32'h0000_000F));
        issue(plain_op(CMD_FREE, 32'hFFFF_FFF3));
        issue(plain_op(CMD_ALLOC, 32'h0));
        issue(plain_op(CMD_USED, 32'h0000_7FEF));
        issue(plain_op(CMD_USED, 32'h0000_7FF0));
        run_random(N_RANDOM);

        write_base(32'hFFFF_FFFF);
        run_random(N_RANDOM);

        // Back-to-back stretch without idling
        write_base($urandom);
        idle_enable = 1'b0;
        run_random(N_RANDOM);
        idle_enable = 1'b1;

        write_base(32'h0000_0000);
        run_random(N_RANDOM);

        settle();
        repeat (MAP_WORDS + 8) @(posedge i_clk);

        $display("covered %0d commands over %0d base settings, wrapped window and range edges",
                 words_sent, base_writes);
        $display("checked %0d results, %0d field mismatches", words_checked, mismatches);
        if (mismatches == 0 && awaited_words.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: block_bitmap_allocator.f
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_map_ram.sv
rtl/bba_cfg.sv
rtl/bba_ctrl.sv
rtl/block_bitmap_allocator.sv
tb/block_bitmap_allocator_test.sv
